// ===== rtl/ascii85_stream_encoder_unit_macros.svh =====
// Assertion macros shared by the ASCII85 stream encoder RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASCII85_STREAM_ENCODER_UNIT_MACROS_SVH
`define ASCII85_STREAM_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define A85_CHECK(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("a85 check failed");

// Next-cycle implication, checked outside reset.
`define A85_CHECK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("a85 check failed");

`endif

// ===== rtl/a85_pkg.sv =====
// Shared types and constants for the ASCII85 stream encoder.
// No dependencies.
package a85_pkg;

    // character codes
    localparam logic [6:0] CH_BANG  = 7'h21;
    localparam logic [6:0] CH_Z     = 7'h7A;
    localparam logic [6:0] CH_NL    = 7'h0A;
    localparam logic [6:0] CH_TILDE = 7'h7E;
    localparam logic [6:0] CH_GT    = 7'h3E;

    localparam int unsigned DIGITS   = 5;
    localparam int unsigned END_LEN  = 4;
    localparam logic [6:0]  BASE85   = 7'd85;

    // q = (v * RECIP_85) >> RECIP_SHIFT is exact for any 32-bit v
    localparam logic [31:0] RECIP_85    = 32'd3233857729;
    localparam int unsigned RECIP_SHIFT = 38;
    localparam int unsigned QUOT_W      = 64 - RECIP_SHIFT;

    // configuration registers
    localparam int unsigned CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP   = 2'd1;
    localparam logic       INVERT_RESET = 1'b1;
    localparam logic [7:0] WRAP_RESET   = 8'd74;

    localparam logic [8:0] COL_MAX = 9'd511;

    // one unit of back-end work: a group and what follows it
    typedef struct packed {
        logic [31:0] value;     // group value, partial groups left-aligned
        logic        zero_grp;  // emit 'z' instead of digits
        logic [2:0]  n_dig;     // digits to emit, 0..5
        logic        wrap_nl;   // line wrap newline after the group
        logic        fin;       // end marker sequence follows
    } t_job;

endpackage

// ===== rtl/a85_front.sv =====
// Front end: config registers, byte inversion, group gathering, column tracking.
// Depends on a85_pkg; pushes one t_job per group or end of stream.
module a85_front import a85_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_job                 o_job
);

    logic        r_invert;
    logic [7:0]  r_wrap;
    logic [23:0] r_val, n_val;
    logic [1:0]  r_fill, n_fill;
    logic [8:0]  r_col, n_col;

    logic        acc;
    logic [7:0]  b;
    logic [31:0] gv;
    logic        complete;
    logic [9:0]  col_sum;
    logic [8:0]  col_sat;
    logic        wrap_nl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= INVERT_RESET;
            r_wrap   <= WRAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INVERT: r_invert <= i_cfg_wdata[0];
                CFG_WRAP:   r_wrap   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_in_stall = i_q_full;
    assign acc        = i_in_valid && !i_q_full;
    assign b          = r_invert ? ~i_data_byte : i_data_byte;
    assign gv         = {r_val, b};
    assign complete   = (r_fill == 2'd3);

    always_comb begin
        col_sum = {1'b0, r_col} + ((gv == 32'd0) ? 10'd1 : 10'd5);
        col_sat = (col_sum > {1'b0, COL_MAX}) ? COL_MAX : col_sum[8:0];
        wrap_nl = complete && (col_sat > {1'b0, r_wrap});
    end

    always_comb begin
        o_job = '0;
        o_job.wrap_nl = wrap_nl;
        o_job.fin     = i_last_byte;
        if (complete) begin
            o_job.value    = gv;
            o_job.zero_grp = (gv == 32'd0);
            o_job.n_dig    = (gv == 32'd0) ? 3'd0 : 3'd5;
        end else if (i_last_byte) begin
            // partial group: zero-pad, emit fill+2 digits
            o_job.n_dig = 3'({1'b0, r_fill} + 3'd2);
            case (r_fill)
                2'd0:    o_job.value = {b, 24'd0};
                2'd1:    o_job.value = {r_val[7:0], b, 16'd0};
                default: o_job.value = {r_val[15:0], b, 8'd0};
            endcase
        end
    end

    assign o_push = acc && (complete || i_last_byte);

    always_comb begin
        n_val  = r_val;
        n_fill = r_fill;
        n_col  = r_col;
        if (acc) begin
            if (i_last_byte) begin
                n_val  = '0;
                n_fill = '0;
                n_col  = '0;
            end else if (complete) begin
                n_val  = '0;
                n_fill = '0;
                n_col  = wrap_nl ? 9'd0 : col_sat;
            end else begin
                n_val  = gv[23:0];
                n_fill = r_fill + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val  <= '0;
            r_fill <= '0;
            r_col  <= '0;
        end else begin
            r_val  <= n_val;
            r_fill <= n_fill;
            r_col  <= n_col;
        end
    end

endmodule

// ===== rtl/a85_queue.sv =====
// Short job queue between front and back ends, register based.
// Depends on a85_pkg for t_job.
module a85_queue import a85_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/a85_back.sv =====
// Back end: base-85 digit unit, character sequencer and output register.
// Depends on a85_pkg and the assertion macros header.
`include "ascii85_stream_encoder_unit_macros.svh"
module a85_back import a85_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_out_char,
    output logic       o_run_last,
    output logic       o_stream_end
);

    // digit unit
    logic              r_cv_full, r_cv_busy, r_cv_ph;
    logic [2:0]        r_cv_idx;
    logic [31:0]       r_cv_val;
    logic [QUOT_W-1:0] r_cv_q;
    t_job              r_cv_job;
    logic [6:0]        r_cv_dig [DIGITS];

    // character sequencer
    logic        r_em_full;
    t_job        r_em_job;
    logic [6:0]  r_em_dig [DIGITS];
    logic [3:0]  r_em_pos, r_em_total;

    // output register
    logic       r_o_valid, r_o_run_last, r_o_end;
    logic [6:0] r_o_char;

    logic        cv_done, handoff, out_load, em_fire, em_end;
    logic [63:0] prod;
    logic [13:0] q85;
    logic [6:0]  rem7;
    logic [2:0]  nfirst_cv, nfirst_em;
    logic [3:0]  total_cv, j, j2;
    logic [6:0]  em_char;

    assign cv_done  = r_cv_full && !r_cv_busy;
    assign out_load = !r_o_valid || !i_out_stall;
    assign em_fire  = r_em_full && out_load;
    assign em_end   = em_fire && (r_em_pos == r_em_total - 4'd1);
    assign handoff  = cv_done && (!r_em_full || em_end);
    assign o_pop    = !i_q_empty && (!r_cv_full || handoff);

    assign prod = 64'(r_cv_val) * 64'(RECIP_85);
    assign q85  = r_cv_q[6:0] * BASE85;
    // remainder is below 85, so the low seven bits suffice
    assign rem7 = r_cv_val[6:0] - q85[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv_full <= 1'b0;
            r_cv_busy <= 1'b0;
            r_cv_ph   <= 1'b0;
            r_cv_idx  <= '0;
        end else if (o_pop) begin
            r_cv_full <= 1'b1;
            r_cv_busy <= (i_job.n_dig != 3'd0);
            r_cv_ph   <= 1'b0;
            r_cv_idx  <= 3'(DIGITS - 1);
        end else begin
            if (handoff) begin
                r_cv_full <= 1'b0;
            end
            if (r_cv_busy) begin
                r_cv_ph <= !r_cv_ph;
                if (r_cv_ph) begin
                    r_cv_idx <= r_cv_idx - 3'd1;
                    if (r_cv_idx == 3'd0) begin
                        r_cv_busy <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cv_job <= i_job;
            r_cv_val <= i_job.value;
        end else if (r_cv_busy) begin
            if (!r_cv_ph) begin
                r_cv_q <= prod[63:RECIP_SHIFT];
            end else begin
                r_cv_dig[r_cv_idx] <= rem7 + CH_BANG;
                r_cv_val           <= 32'(r_cv_q);
            end
        end
    end

    // character count of the job held by the digit unit
    always_comb begin
        nfirst_cv = r_cv_job.zero_grp ? 3'd1 : r_cv_job.n_dig;
        total_cv  = {1'b0, nfirst_cv} + {3'd0, r_cv_job.wrap_nl}
                  + (r_cv_job.fin ? 4'(END_LEN) : 4'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_full <= 1'b0;
            r_em_pos  <= '0;
        end else if (handoff) begin
            r_em_full <= 1'b1;
            r_em_pos  <= '0;
        end else if (em_end) begin
            r_em_full <= 1'b0;
        end else if (em_fire) begin
            r_em_pos <= r_em_pos + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (handoff) begin
            r_em_job   <= r_cv_job;
            r_em_dig   <= r_cv_dig;
            r_em_total <= total_cv;
        end
    end

    // character at the current sequence position
    always_comb begin
        nfirst_em = r_em_job.zero_grp ? 3'd1 : r_em_job.n_dig;
        j         = r_em_pos - {1'b0, nfirst_em};
        j2        = j - {3'd0, r_em_job.wrap_nl};
        em_char   = CH_NL;
        if (r_em_pos < {1'b0, nfirst_em}) begin
            em_char = r_em_job.zero_grp ? CH_Z : r_em_dig[r_em_pos[2:0]];
        end else if (r_em_job.wrap_nl && j == 4'd0) begin
            em_char = CH_NL;
        end else begin
            case (j2[1:0])
                2'd1:    em_char = CH_TILDE;
                2'd2:    em_char = CH_GT;
                default: em_char = CH_NL;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= em_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_fire) begin
            r_o_char     <= em_char;
            r_o_run_last <= em_end;
            r_o_end      <= em_end && r_em_job.fin;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_char   = r_o_char;
    assign o_run_last   = r_o_run_last;
    assign o_stream_end = r_o_end;

    `A85_CHECK(a_end_is_last, i_clk, i_rst_n, r_o_valid && r_o_end, r_o_run_last)
    `A85_CHECK(a_busy_has_job, i_clk, i_rst_n, r_cv_busy, r_cv_full)
    `A85_CHECK(a_pos_in_range, i_clk, i_rst_n, r_em_full, r_em_pos < r_em_total)
    `A85_CHECK_NEXT(a_pop_starts, i_clk, i_rst_n, o_pop && i_job.n_dig != 3'd0, r_cv_busy)

endmodule

// ===== rtl/ascii85_stream_encoder_unit.sv =====
// ASCII85 stream encoder, top level.
// Depends on a85_pkg, a85_front, a85_queue and a85_back.
//
// Encodes a byte stream as ASCII85 text. Bytes (optionally inverted, per the
// invert register) are gathered into big-endian 4-byte groups; an all-zero
// group becomes 'z', any other group five base-85 digits starting at '!'.
// A newline follows a group once the line column exceeds the wrap register.
// The byte flagged last flushes a partial group (n bytes give n+1 digits, no
// 'z', no wrap check) and closes the stream with newline, "~>" and newline;
// run_last marks the last character caused by a byte and stream_end the very
// last newline. The input side takes one byte per cycle as long as
// the job queue (QUEUE_DEPTH entries) has room; bytes that do not finish a
// group cost nothing downstream. Each finished group or end of stream passes
// through the shared digit unit, which works only on digit groups (one
// reciprocal multiply and one remainder step per digit), overlapped with
// emission of the previous group's 1 to 10 characters at one per cycle
// while the output is not stalled; zero groups skip the digit steps.
// Configuration writes take effect at once and belong in idle periods.
module ascii85_stream_encoder_unit import a85_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_wdata,
    // byte requests
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    // character requests
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [6:0]           o_out_char,
    output logic                 o_run_last,
    output logic                 o_stream_end
);

    logic q_push, q_pop, q_full, q_empty;
    t_job q_in, q_out;

    // gathers groups, tracks the line column, decides wraps
    a85_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (q_in)
    );

    // decouples byte intake from character output
    a85_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_empty (q_empty)
    );

    // digit conversion and character serialization
    a85_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_job        (q_out),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_char   (o_out_char),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end)
    );

endmodule
